>>> rtl/core/packed_sign_vector_dot_product_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packed sign vector dot product
// Concurrent checks clocked by clk_i and gated by rst_ni; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef PACKED_SIGN_VECTOR_DOT_PRODUCT_DEFINES_SVH
`define PACKED_SIGN_VECTOR_DOT_PRODUCT_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, checked out of reset
`define PSVDP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
// antecedent implies consequent in the same cycle
`define PSVDP_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication failed");
// antecedent implies consequent in the next cycle
`define PSVDP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");
`else
`define PSVDP_ASSERT(name, prop)
`define PSVDP_ASSERT_IMPLY(name, ante, cons)
`define PSVDP_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> rtl/core/psvdp_pkg.sv
// ---------------------------------------------------------------------------
// psvdp_pkg
// Shared constants and register codes of the packed sign vector dot product.
// ---------------------------------------------------------------------------
`default_nettype none

package psvdp_pkg;

  localparam int unsigned WORD_BITS_DEF    = 32;
  localparam int unsigned MAX_COLUMNS_DEF  = 4096;
  localparam int unsigned ROW_LENGTH_RESET = 32;

  // byte address width of the register port
  localparam int unsigned APB_ADDR_W = 3;

  // register index = paddr[APB_ADDR_W-1:2]
  typedef enum logic [APB_ADDR_W-3:0] {
    REG_ROW_LENGTH = 1'b0
  } reg_idx_e;

endpackage

`default_nettype wire

>>> rtl/core/psvdp_cfg_regs.sv
// ---------------------------------------------------------------------------
// psvdp_cfg_regs
// Register port: holds row_length and derives the valid bit count of the
// last word of a vector.
// ---------------------------------------------------------------------------
`default_nettype none

module psvdp_cfg_regs #(
  parameter int unsigned WORD_BITS   = psvdp_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_COLUMNS = psvdp_pkg::MAX_COLUMNS_DEF,
  localparam int unsigned RL_W       = $clog2(MAX_COLUMNS) + 1,
  localparam int unsigned CNT_W      = $clog2(WORD_BITS + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [psvdp_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  output logic      [CNT_W-1:0]                  last_bits_o
);

  // quotient by WORD_BITS through a reciprocal: q = (x * RECIP) >> SH,
  // exact for every x below 2**RL_W
  localparam int unsigned SH      = RL_W + $clog2(WORD_BITS);
  localparam int unsigned RCP_W   = RL_W + 1;
  localparam int unsigned PROD_W  = RL_W + RCP_W;
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);
  localparam logic [RL_W-1:0] Q_RESET = RL_W'((psvdp_pkg::ROW_LENGTH_RESET - 1) / WORD_BITS);

  logic [RL_W-1:0]   row_length_q, row_length_d;
  logic [RL_W-1:0]   quot_q, quot_d;
  logic              wr_en;
  logic [RL_W-1:0]   wr_len_m1;
  logic [PROD_W-1:0] wr_prod;
  logic [RL_W-1:0]   quot_times_w;
  logic [RL_W-1:0]   rem_plus1;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // (len - 1) / WORD_BITS, taken at write time
  assign wr_len_m1 = pwdata[RL_W-1:0] - RL_W'(1);
  assign wr_prod   = PROD_W'(wr_len_m1) * PROD_W'(RECIP);

  always_comb begin
    row_length_d = row_length_q;
    quot_d       = quot_q;
    if (wr_en) begin
      case (psvdp_pkg::reg_idx_e'(paddr[psvdp_pkg::APB_ADDR_W-1:2]))
        psvdp_pkg::REG_ROW_LENGTH: begin
          row_length_d = pwdata[RL_W-1:0];
          quot_d       = RL_W'(wr_prod >> SH);
        end
        default: begin
          row_length_d = row_length_q;
          quot_d       = quot_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= RL_W'(psvdp_pkg::ROW_LENGTH_RESET);
      quot_q       <= Q_RESET;
    end else begin
      row_length_q <= row_length_d;
      quot_q       <= quot_d;
    end
  end

  always_comb begin
    case (psvdp_pkg::reg_idx_e'(paddr[psvdp_pkg::APB_ADDR_W-1:2]))
      psvdp_pkg::REG_ROW_LENGTH: prdata = 32'(row_length_q);
      default:                   prdata = 32'd0;
    endcase
  end

  // len - q*W = ((len - 1) mod W) + 1; zero length counts a full word
  assign quot_times_w = RL_W'(quot_q * RL_W'(WORD_BITS));
  assign rem_plus1    = row_length_q - quot_times_w;
  assign last_bits_o  = (row_length_q == '0) ? CNT_W'(WORD_BITS) : CNT_W'(rem_plus1);

endmodule

`default_nettype wire

>>> rtl/core/psvdp_word_score.sv
// ---------------------------------------------------------------------------
// psvdp_word_score
// Popcount tree over the agreeing bits of one word; yields matches minus
// mismatches for the counted bits.
// ---------------------------------------------------------------------------
`default_nettype none

module psvdp_word_score #(
  parameter int unsigned WORD_BITS = psvdp_pkg::WORD_BITS_DEF,
  localparam int unsigned CNT_W    = $clog2(WORD_BITS + 1)
) (
  input  wire logic [WORD_BITS-1:0] agree_i,
  input  wire logic [CNT_W-1:0]     nbits_i,
  output logic signed [CNT_W+1:0]   score_o
);

  localparam int unsigned LEVELS = $clog2(WORD_BITS);
  localparam int unsigned PAD    = 1 << LEVELS;

  // heap-ordered adder tree, node 1 is the root
  logic [CNT_W-1:0] node [1:2*PAD-1];

  for (genvar i = 0; i < PAD; i++) begin : g_leaf
    if (i < WORD_BITS) begin : g_bit
      assign node[PAD+i] = CNT_W'(agree_i[i]);
    end else begin : g_pad
      assign node[PAD+i] = '0;
    end
  end

  for (genvar k = 1; k < PAD; k++) begin : g_add
    assign node[k] = node[2*k] + node[2*k+1];
  end

  // 2*matches - counted bits
  assign score_o = signed'({1'b0, node[1], 1'b0}) - signed'({2'b00, nbits_i});

endmodule

`default_nettype wire

>>> rtl/core/packed_sign_vector_dot_product.sv
// ---------------------------------------------------------------------------
// packed_sign_vector_dot_product
// XNOR / popcount dot product of two packed +1/-1 sign vectors.
// ---------------------------------------------------------------------------
// Each transaction on the input channel carries one pair of WORD_BITS-bit
// words (bit 1 = +1, bit 0 = -1) and a last_word flag. Every agreeing bit adds
// +1 and every disagreeing bit -1 to a running sum, saturated at
// +/-MAX_COLUMNS. In the word flagged last only the low
// ((row_length-1) mod WORD_BITS)+1 bits count (all bits when row_length is 0);
// that word emits the sum as one output transaction and clears the sum.
// Throughput is one word per clock. The datapath is an input register
// (masked XNOR of the pair), then the popcount tree plus saturating
// accumulator into the result register, so each result passes through both
// registers on its way out. in_stall_o rises only when a last word sits in the
// input register while the previous result is still held by out_stall_i;
// non-last words keep flowing behind a held result. row_length is written
// through the APB port at byte address 0 and must be written only while the
// block is idle; it takes effect for the next word accepted.
// ---------------------------------------------------------------------------
`default_nettype none
`include "packed_sign_vector_dot_product_defines.svh"

module packed_sign_vector_dot_product #(
  parameter int unsigned WORD_BITS   = psvdp_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_COLUMNS = psvdp_pkg::MAX_COLUMNS_DEF,
  localparam int unsigned SUM_W      = $clog2(MAX_COLUMNS) + 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [psvdp_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  // word input
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [WORD_BITS-1:0]              word_a_i,
  input  wire logic [WORD_BITS-1:0]              word_b_i,
  input  wire logic                              last_word_i,
  // result output
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [SUM_W-1:0]                dot_sum_o
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);
  localparam int unsigned SC_W  = CNT_W + 2;
  // wide enough for sum + score without overflow
  localparam int unsigned EXT_W = ((SUM_W > SC_W) ? SUM_W : SC_W) + 1;

  localparam logic signed [EXT_W-1:0] EXT_HI = EXT_W'(MAX_COLUMNS);
  localparam logic signed [EXT_W-1:0] EXT_LO = -EXT_HI;
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(MAX_COLUMNS);
  localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI;

  // -------------------------------------------------------------------------
  // registers
  // -------------------------------------------------------------------------
  logic [CNT_W-1:0] last_bits;

  psvdp_cfg_regs #(
    .WORD_BITS   (WORD_BITS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .last_bits_o (last_bits)
  );

  // -------------------------------------------------------------------------
  // input stage: masked agreement vector and counted bit count
  // -------------------------------------------------------------------------
  logic                 in_accept;
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_last_q;
  logic [WORD_BITS-1:0] s1_agree_q, agree_d;
  logic [CNT_W-1:0]     s1_nbits_q, nbits_d;
  logic [WORD_BITS-1:0] live_mask;
  logic                 s1_consume;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      live_mask[i] = !last_word_i || (CNT_W'(i) < last_bits);
    end
  end

  assign agree_d = ~(word_a_i ^ word_b_i) & live_mask;
  assign nbits_d = last_word_i ? last_bits : CNT_W'(WORD_BITS);

  // a last word needs room in the result register; others always drain
  assign s1_consume = s1_valid_q && (!s1_last_q || !out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_consume;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_consume) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_agree_q <= agree_d;
      s1_nbits_q <= nbits_d;
      s1_last_q  <= last_word_i;
    end
  end

  // -------------------------------------------------------------------------
  // accumulate stage
  // -------------------------------------------------------------------------
  logic signed [SC_W-1:0]  score;
  logic signed [EXT_W-1:0] sum_ext;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [SUM_W-1:0] running_sum_q, running_sum_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] dot_sum_q;
  logic                    result_load;

  psvdp_word_score #(
    .WORD_BITS (WORD_BITS)
  ) u_word_score (
    .agree_i (s1_agree_q),
    .nbits_i (s1_nbits_q),
    .score_o (score)
  );

  assign sum_ext = EXT_W'(running_sum_q) + EXT_W'(score);

  always_comb begin
    if (sum_ext > EXT_HI) begin
      sum_sat = SUM_HI;
    end else if (sum_ext < EXT_LO) begin
      sum_sat = SUM_LO;
    end else begin
      sum_sat = SUM_W'(sum_ext);
    end
  end

  assign result_load = s1_consume && s1_last_q;

  always_comb begin
    running_sum_d = running_sum_q;
    if (result_load) begin
      running_sum_d = '0;
    end else if (s1_consume) begin
      running_sum_d = sum_sat;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      running_sum_q <= running_sum_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_load) begin
      dot_sum_q <= sum_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_sum_o   = dot_sum_q;

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------
  `PSVDP_ASSERT(a_sum_in_range, (running_sum_q <= SUM_HI) && (running_sum_q >= SUM_LO))
  `PSVDP_ASSERT_IMPLY(a_result_in_range, out_valid_q, (dot_sum_q <= SUM_HI) && (dot_sum_q >= SUM_LO))
  `PSVDP_ASSERT_IMPLY(a_stall_cause, in_stall_o, s1_valid_q && s1_last_q && out_valid_q && out_stall_i)
  `PSVDP_ASSERT_NEXT(a_clear_on_last, result_load, (running_sum_q == '0) && out_valid_q)
  `PSVDP_ASSERT_IMPLY(a_result_source, $rose(out_valid_q), $past(s1_valid_q && s1_last_q))

endmodule

`default_nettype wire
